>>> design/assert_macros.svh
// assertion macros shared by the sound generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/psg_pkg.sv
// package: types and constants of the pulse and saw sound generator
`timescale 1ns / 1ps

package psg_pkg;

   // saw sequence length, 2 to 16
   localparam int unsigned SAW_PHASES = 14;

   localparam logic [15:0] ADDR_MASK = 16'hF003;

   // register addresses after masking
   localparam logic [15:0] REG_PA_CTRL = 16'h9000;
   localparam logic [15:0] REG_PA_LO   = 16'h9001;
   localparam logic [15:0] REG_PA_HI   = 16'h9002;
   localparam logic [15:0] REG_PB_CTRL = 16'hA000;
   localparam logic [15:0] REG_PB_LO   = 16'hA001;
   localparam logic [15:0] REG_PB_HI   = 16'hA002;
   localparam logic [15:0] REG_SAW_RATE = 16'hB000;
   localparam logic [15:0] REG_SAW_LO  = 16'hB001;
   localparam logic [15:0] REG_SAW_HI  = 16'hB002;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } psg_op_type;

   // register write strobes for one pulse channel
   typedef struct packed {
      logic ctrl;
      logic period_lo;
      logic period_hi;
   } psg_pulse_wr_type;

endpackage

>>> design/psg_if.sv
// handshake interfaces for the request and response channels
`timescale 1ns / 1ps

interface psg_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output operation, output address, output data, input ready);
   modport sink (input valid, input operation, input address, input data, output ready);
endinterface

interface psg_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] pulse_a_level;
   logic [3:0] pulse_b_level;
   logic [4:0] saw_level;

   modport source (output valid, output pulse_a_level, output pulse_b_level,
                   output saw_level, input ready);
   modport sink (input valid, input pulse_a_level, input pulse_b_level,
                 input saw_level, output ready);
endinterface

>>> design/pulse_and_saw_sound_generator.sv
// top level: two pulse channels and one sawtooth channel behind beat handshakes
// a beat waits in the input register; a tick beat's result is registered into
//   the held levels and rsp valid as the beat leaves that register
// throughput: one beat per cycle, ticks and writes alike, while rsp keeps up
// the held channel levels double as the response register
// reset: synchronous, active high; clears all channel state and the swap bit
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pulse_and_saw_sound_generator (
   input  logic       clock,
   input  logic       reset,
   psg_req_if.sink    req_bus,
   psg_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import psg_pkg::*;

   // configuration: address line swap
   logic swap_ff;

   // input register stage
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_operation_ff;
   logic [15:0] s1_address_ff;
   logic [7:0]  s1_data_ff;

   // handshake control
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;
   logic s1_advance;
   logic tick;
   logic wr;

   // decode
   logic [15:0]      addr_swapped;
   logic [15:0]      addr_masked;
   psg_pulse_wr_type pa_wr, pb_wr;
   logic             saw_rate_we, saw_lo_we, saw_hi_we;

   // saw channel state
   logic [5:0]  saw_rate_ff, saw_rate_in;
   logic [11:0] saw_period_ff, saw_period_in;
   logic        saw_enable_ff, saw_enable_in;
   logic [11:0] saw_divider_ff, saw_divider_in;
   logic [3:0]  saw_phase_ff, saw_phase_in;
   logic [7:0]  saw_sum_ff, saw_sum_in;
   logic [4:0]  saw_level_ff, saw_level_in;

   logic [3:0] pulse_a_level, pulse_b_level;

   // ---- handshake ----
   // a tick may only retire when the response slot is empty or draining;
   // a write never produces a beat so it always retires
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign s1_advance  = s1_valid_ff && ((s1_operation_ff == OP_WRITE) || rsp_free);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign tick = s1_valid_ff && (s1_operation_ff == OP_TICK) && rsp_free;
   assign wr   = s1_valid_ff && (s1_operation_ff == OP_WRITE);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            swap_ff <= csr_write_data;
         end
      end
   end

   // input payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_operation_ff <= req_bus.operation;
         s1_address_ff   <= req_bus.address;
         s1_data_ff      <= req_bus.data;
      end
   end

   // ---- register decode ----
   // board variant swaps address bits 0 and 1 before decode
   assign addr_swapped = swap_ff ? {s1_address_ff[15:2], s1_address_ff[0], s1_address_ff[1]}
                                 : s1_address_ff;
   assign addr_masked  = addr_swapped & ADDR_MASK;

   always_comb begin
      pa_wr       = '0;
      pb_wr       = '0;
      saw_rate_we = 1'b0;
      saw_lo_we   = 1'b0;
      saw_hi_we   = 1'b0;
      if (wr) begin
         unique case (addr_masked)
            REG_PA_CTRL:  pa_wr.ctrl      = 1'b1;
            REG_PA_LO:    pa_wr.period_lo = 1'b1;
            REG_PA_HI:    pa_wr.period_hi = 1'b1;
            REG_PB_CTRL:  pb_wr.ctrl      = 1'b1;
            REG_PB_LO:    pb_wr.period_lo = 1'b1;
            REG_PB_HI:    pb_wr.period_hi = 1'b1;
            REG_SAW_RATE: saw_rate_we     = 1'b1;
            REG_SAW_LO:   saw_lo_we       = 1'b1;
            REG_SAW_HI:   saw_hi_we       = 1'b1;
            default:      ; // unmapped addresses, 9003 included, do nothing
         endcase
      end
   end

   // ---- pulse channels ----
   psg_pulse u_pulse_a (
      .clock   (clock),
      .reset   (reset),
      .tick    (tick),
      .wr      (pa_wr),
      .wr_data (s1_data_ff),
      .level   (pulse_a_level)
   );

   psg_pulse u_pulse_b (
      .clock   (clock),
      .reset   (reset),
      .tick    (tick),
      .wr      (pb_wr),
      .wr_data (s1_data_ff),
      .level   (pulse_b_level)
   );

   // ---- saw channel ----
   // phase 0 clears the accumulator, even phases add the rate and refresh
   // the level from sum bits 7..3, odd phases just pass
   always_comb begin
      saw_rate_in    = saw_rate_ff;
      saw_period_in  = saw_period_ff;
      saw_enable_in  = saw_enable_ff;
      saw_divider_in = saw_divider_ff;
      saw_phase_in   = saw_phase_ff;
      saw_sum_in     = saw_sum_ff;
      saw_level_in   = saw_level_ff;
      if (saw_rate_we) begin
         saw_rate_in = s1_data_ff[5:0];
      end
      if (saw_lo_we) begin
         saw_period_in[7:0] = s1_data_ff;
      end
      if (saw_hi_we) begin
         saw_period_in[11:8] = s1_data_ff[3:0];
         saw_enable_in       = s1_data_ff[7];
      end
      if (tick) begin
         if (saw_divider_ff == 12'd0) begin
            saw_divider_in = saw_period_ff;
            if (saw_phase_ff == 4'd0) begin
               saw_sum_in = 8'd0;
            end else if (!saw_phase_ff[0]) begin
               saw_sum_in   = saw_sum_ff + {2'b00, saw_rate_ff};
               saw_level_in = saw_enable_ff ? saw_sum_in[7:3] : 5'd0;
            end
            if ({1'b0, saw_phase_ff} == 5'(SAW_PHASES - 1)) begin
               saw_phase_in = 4'd0;
            end else begin
               saw_phase_in = saw_phase_ff + 4'd1;
            end
         end else begin
            saw_divider_in = saw_divider_ff - 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saw_rate_ff    <= '0;
         saw_period_ff  <= '0;
         saw_enable_ff  <= 1'b0;
         saw_divider_ff <= '0;
         saw_phase_ff   <= '0;
         saw_sum_ff     <= '0;
         saw_level_ff   <= '0;
      end else begin
         saw_rate_ff    <= saw_rate_in;
         saw_period_ff  <= saw_period_in;
         saw_enable_ff  <= saw_enable_in;
         saw_divider_ff <= saw_divider_in;
         saw_phase_ff   <= saw_phase_in;
         saw_sum_ff     <= saw_sum_in;
         saw_level_ff   <= saw_level_in;
      end
   end

   // ---- response ----
   // held levels only move on a tick, and a tick waits for a free slot,
   // so they stay put while a beat is stalled
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pulse_a_level = pulse_a_level;
   assign rsp_bus.pulse_b_level = pulse_b_level;
   assign rsp_bus.saw_level     = saw_level_ff;

   // ---- assertions ----
   `ASSERT_NEXT(a_tick_gives_beat, clock, reset, tick, rsp_valid_ff)
   `ASSERT_IMP(a_phase_range, clock, reset, 1'b1, {1'b0, saw_phase_ff} < 5'(SAW_PHASES))
   `ASSERT_NEXT(a_stall_holds_levels, clock, reset, rsp_valid_ff && !rsp_bus.ready, $stable(saw_level_ff) && $stable(pulse_a_level) && $stable(pulse_b_level))

endmodule

>>> design/psg_pulse.sv
// one pulse channel: registers, period divider, duty sequencer, held level
`timescale 1ns / 1ps

module psg_pulse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick,
   input  psg_pkg::psg_pulse_wr_type wr,
   input  logic [7:0]                wr_data,
   output logic [3:0]                level
);
   import psg_pkg::*;

   logic [3:0]  volume_ff, volume_in;
   logic [2:0]  duty_ff, duty_in;
   logic        ignore_duty_ff, ignore_duty_in;
   logic [11:0] period_ff, period_in;
   logic        enable_ff, enable_in;
   logic [11:0] divider_ff, divider_in;
   logic [3:0]  step_ff, step_in;
   logic [3:0]  level_ff, level_in;

   always_comb begin
      volume_in      = volume_ff;
      duty_in        = duty_ff;
      ignore_duty_in = ignore_duty_ff;
      period_in      = period_ff;
      enable_in      = enable_ff;
      divider_in     = divider_ff;
      step_in        = step_ff;
      level_in       = level_ff;
      if (wr.ctrl) begin
         volume_in      = wr_data[3:0];
         duty_in        = wr_data[6:4];
         ignore_duty_in = wr_data[7];
      end
      if (wr.period_lo) begin
         period_in[7:0] = wr_data;
      end
      if (wr.period_hi) begin
         period_in[11:8] = wr_data[3:0];
         enable_in       = wr_data[7];
      end
      if (tick) begin
         if (divider_ff == 12'd0) begin
            divider_in = period_ff;
            step_in    = step_ff - 4'd1;
            if (enable_ff && ((step_in <= {1'b0, duty_ff}) || ignore_duty_ff)) begin
               level_in = volume_ff;
            end else begin
               level_in = 4'd0;
            end
         end else begin
            divider_in = divider_ff - 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff      <= '0;
         duty_ff        <= '0;
         ignore_duty_ff <= 1'b0;
         period_ff      <= '0;
         enable_ff      <= 1'b0;
         divider_ff     <= '0;
         step_ff        <= '0;
         level_ff       <= '0;
      end else begin
         volume_ff      <= volume_in;
         duty_ff        <= duty_in;
         ignore_duty_ff <= ignore_duty_in;
         period_ff      <= period_in;
         enable_ff      <= enable_in;
         divider_ff     <= divider_in;
         step_ff        <= step_in;
         level_ff       <= level_in;
      end
   end

   assign level = level_ff;

endmodule

>>> sim/tb.sv
// testbench for the pulse and saw sound generator: predicted channel levels checked per rsp beat
`timescale 1ns / 1ps

module tb;
   import psg_pkg::*;

   // cycles with no beat on either side before the run is abandoned
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   // length of the one long receiver hold-off
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   // chance in a hundred that a side idles in a given cycle
   localparam int unsigned IDLE_PERCENT = 9;
   // decodes like a pulse register but is ignored by the block
   localparam logic [15:0] REG_PA_SPARE = 16'h9003;

   typedef struct packed {
      psg_op_type  op;
      logic [15:0] addr;
      logic [7:0]  data;
   } beat_type;

   typedef struct packed {
      logic [3:0] pulse_a;
      logic [3:0] pulse_b;
      logic [4:0] saw;
   } levels_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   // driven values start known at time zero
   logic        req_valid = 1'b0;
   psg_op_type  req_op    = OP_TICK;
   logic [15:0] req_addr  = '0;
   logic [7:0]  req_data  = '0;
   logic        rsp_ready = 1'b0;

   psg_req_if req_bus ();
   psg_rsp_if rsp_bus ();

   assign req_bus.valid     = req_valid;
   assign req_bus.operation = req_op;
   assign req_bus.address   = req_addr;
   assign req_bus.data      = req_data;
   assign rsp_bus.ready     = rsp_ready;

   pulse_and_saw_sound_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // beats waiting to be offered, and levels waiting to come back
   beat_type   pending_beats[$];
   levels_type expected_levels[$];

   int unsigned beats_offered = 0;
   int unsigned beats_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned holds_requested = 0;
   int unsigned holds_started = 0;
   int unsigned hold_left = 0;
   logic        steady = 1'b0;

   // shadow copy of the generator state
   logic        line_swap = 1'b0;
   logic [3:0]  pulse_volume [2];
   logic [2:0]  pulse_duty [2];
   logic        pulse_ignore_duty [2];
   logic [11:0] pulse_period [2];
   logic        pulse_enable [2];
   logic [11:0] pulse_count [2];
   logic [3:0]  pulse_step [2];
   logic [3:0]  pulse_level [2];
   logic [5:0]  saw_rate;
   logic [11:0] saw_period;
   logic        saw_enable;
   logic [11:0] saw_count;
   logic [3:0]  saw_phase;
   logic [7:0]  saw_sum;
   logic [4:0]  saw_level;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_error(string msg);
      $display("error at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic void clear_generator();
      for (int ch = 0; ch < 2; ch++) begin
         pulse_volume[ch]      = '0;
         pulse_duty[ch]        = '0;
         pulse_ignore_duty[ch] = 1'b0;
         pulse_period[ch]      = '0;
         pulse_enable[ch]      = 1'b0;
         pulse_count[ch]       = '0;
         pulse_step[ch]        = '0;
         pulse_level[ch]       = '0;
      end
      saw_rate   = '0;
      saw_period = '0;
      saw_enable = 1'b0;
      saw_count  = '0;
      saw_phase  = '0;
      saw_sum    = '0;
      saw_level  = '0;
   endfunction

   // board variant: address lines 0 and 1 crossed
   function automatic logic [15:0] swap_lines(logic [15:0] addr);
      return {addr[15:2], addr[0], addr[1]};
   endfunction

   function automatic void write_register(logic [15:0] addr, logic [7:0] data);
      logic [15:0] reg_addr;
      int          ch;
      reg_addr = (line_swap ? swap_lines(addr) : addr) & ADDR_MASK;
      ch = (reg_addr[15:12] == REG_PB_CTRL[15:12]) ? 1 : 0;
      case (reg_addr)
         REG_PA_CTRL, REG_PB_CTRL: begin
            pulse_volume[ch]      = data[3:0];
            pulse_duty[ch]        = data[6:4];
            pulse_ignore_duty[ch] = data[7];
         end
         REG_PA_LO, REG_PB_LO: pulse_period[ch][7:0] = data;
         REG_PA_HI, REG_PB_HI: begin
            pulse_period[ch][11:8] = data[3:0];
            pulse_enable[ch]       = data[7];
         end
         REG_SAW_RATE: saw_rate = data[5:0];
         REG_SAW_LO: saw_period[7:0] = data;
         REG_SAW_HI: begin
            saw_period[11:8] = data[3:0];
            saw_enable       = data[7];
         end
         default: ;
      endcase
   endfunction

   // divider at zero: reload, count the duty step down and latch the level
   function automatic void step_pulse(int ch);
      if (pulse_count[ch] == 12'd0) begin
         pulse_count[ch] = pulse_period[ch];
         pulse_step[ch]  = pulse_step[ch] - 4'd1;
         if (pulse_enable[ch] &&
             (pulse_step[ch] <= {1'b0, pulse_duty[ch]} || pulse_ignore_duty[ch]))
            pulse_level[ch] = pulse_volume[ch];
         else
            pulse_level[ch] = '0;
      end else begin
         pulse_count[ch] = pulse_count[ch] - 12'd1;
      end
   endfunction

   // phase 0 clears the sum, other even phases accumulate, odd phases rest
   function automatic void step_saw();
      if (saw_count == 12'd0) begin
         saw_count = saw_period;
         if (saw_phase == 4'd0) begin
            saw_sum = '0;
         end else if (!saw_phase[0]) begin
            saw_sum   = saw_sum + {2'b00, saw_rate};
            saw_level = saw_enable ? saw_sum[7:3] : '0;
         end
         saw_phase = (saw_phase + 1 == SAW_PHASES) ? 4'd0 : saw_phase + 4'd1;
      end else begin
         saw_count = saw_count - 12'd1;
      end
   endfunction

   function automatic void apply_beat(beat_type b);
      if (b.op == OP_WRITE) begin
         write_register(b.addr, b.data);
      end else begin
         step_pulse(0);
         step_pulse(1);
         step_saw();
         expected_levels.push_back(levels_type'{pulse_level[0], pulse_level[1], saw_level});
      end
   endfunction

   // mostly ticks and writes to live registers with short periods, some stray writes
   function automatic beat_type random_beat();
      beat_type    b;
      logic [15:0] target;
      int unsigned pick;
      b.op   = OP_TICK;
      b.addr = 16'($urandom);
      b.data = 8'($urandom);
      pick   = $urandom_range(99);
      if (pick < 65)
         return b;
      b.op = OP_WRITE;
      if (pick >= 96)
         return b;
      case ($urandom_range(9))
         0: target = REG_PA_CTRL;
         1: target = REG_PA_LO;
         2: target = REG_PA_HI;
         3: target = REG_PB_CTRL;
         4: target = REG_PB_LO;
         5: target = REG_PB_HI;
         6: target = REG_SAW_RATE;
         7: target = REG_SAW_LO;
         8: target = REG_SAW_HI;
         default: target = REG_PA_SPARE;
      endcase
      // long periods stall a channel for thousands of ticks, keep them rare
      if (target[1:0] == REG_PA_LO[1:0] && $urandom_range(3) != 0)
         b.data = 8'($urandom_range(15));
      if (target[1:0] == REG_PA_HI[1:0]) begin
         if ($urandom_range(63) != 0)
            b.data[3:0] = '0;
         if ($urandom_range(4) != 0)
            b.data[7] = 1'b1;
      end
      // don't-care address bits stay random; pre-cross lines so the target is hit
      b.addr = target | (b.addr & ~ADDR_MASK);
      if (line_swap)
         b.addr = swap_lines(b.addr);
      return b;
   endfunction

   task automatic queue_beat(psg_op_type op, logic [15:0] addr, logic [7:0] data);
      pending_beats.push_back(beat_type'{op, addr, data});
   endtask

   task automatic queue_random(int unsigned count);
      repeat (count) pending_beats.push_back(random_beat());
   endtask

   // sender pause: nothing queued, nothing offered, nothing owed
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_valid || expected_levels.size() != 0)
         @(posedge clock);
      // a trailing write may still sit in the input register
      repeat (4) @(posedge clock);
   endtask

   task automatic set_line_swap(logic value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      line_swap = value;
   endtask

   // request driver: a beat is held until taken, then the next one may follow
   always @(negedge clock) begin : drive_requests
      beat_type next_beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (beats_accepted == beats_offered) begin
         if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_beat = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_op    <= next_beat.op;
            req_addr  <= next_beat.addr;
            req_data  <= next_beat.data;
            beats_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready: random stalls, plus the one long hold-off on request
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holds_started != holds_requested) begin
            holds_started = holds_requested;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // monitor: checks response beats, feeds accepted request beats to the predictor
   always @(posedge clock) begin : watch_beats
      levels_type got;
      levels_type want;
      logic       moved;
      moved = 1'b0;
      if (reset) begin
         clear_generator();
         expected_levels.delete();
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            moved = 1'b1;
            got = levels_type'{rsp_bus.pulse_a_level, rsp_bus.pulse_b_level,
                               rsp_bus.saw_level};
            if (expected_levels.size() == 0) begin
               report_error($sformatf("result %0h/%0h/%0h with none expected",
                                      got.pulse_a, got.pulse_b, got.saw));
            end else begin
               want = expected_levels.pop_front();
               if (got.pulse_a !== want.pulse_a)
                  report_error($sformatf("result %0d pulse_a_level %0h, expected %0h",
                                         results_checked, got.pulse_a, want.pulse_a));
               if (got.pulse_b !== want.pulse_b)
                  report_error($sformatf("result %0d pulse_b_level %0h, expected %0h",
                                         results_checked, got.pulse_b, want.pulse_b));
               if (got.saw !== want.saw)
                  report_error($sformatf("result %0d saw_level %0h, expected %0h",
                                         results_checked, got.saw, want.saw));
            end
            results_checked++;
         end
         if (req_valid && req_bus.ready) begin
            moved = 1'b1;
            beats_accepted++;
            apply_beat(beat_type'{req_op, req_addr, req_data});
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : run_test
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: plain swap setting written explicitly
      set_line_swap(1'b0);
      // a tick straight out of reset, with every payload bit set
      queue_beat(OP_TICK, 16'hFFFF, 8'hFF);
      // pulse a: full volume, widest duty, duty ignored, period 0, enabled
      queue_beat(OP_WRITE, REG_PA_CTRL, 8'hFF);
      queue_beat(OP_WRITE, REG_PA_LO, 8'h00);
      queue_beat(OP_WRITE, REG_PA_HI, 8'h80);
      // pulse b: volume 10, duty 3, period 1
      queue_beat(OP_WRITE, REG_PB_CTRL, 8'h3A);
      queue_beat(OP_WRITE, REG_PB_LO, 8'h01);
      queue_beat(OP_WRITE, REG_PB_HI, 8'h80);
      // saw: largest rate, period 0, enabled
      queue_beat(OP_WRITE, REG_SAW_RATE, 8'hFF);
      queue_beat(OP_WRITE, REG_SAW_LO, 8'h00);
      queue_beat(OP_WRITE, REG_SAW_HI, 8'h80);
      // writes that decode to nothing
      queue_beat(OP_WRITE, REG_PA_SPARE, 8'hFF);
      queue_beat(OP_WRITE, 16'h0000, 8'hFF);
      queue_beat(OP_WRITE, 16'hFFFF, 8'h00);
      repeat (8) queue_beat(OP_TICK, 16'h0000, 8'h00);
      // disabled pulse a keeps stepping but falls silent
      queue_beat(OP_WRITE, REG_PA_HI, 8'h00);
      queue_beat(OP_TICK, 16'h0000, 8'h00);
      queue_beat(OP_TICK, 16'h0000, 8'h00);
      // disabled saw keeps accumulating, level forced low
      queue_beat(OP_WRITE, REG_SAW_HI, 8'h70);
      repeat (3) queue_beat(OP_TICK, 16'h0000, 8'h00);
      wait_drained();

      // crossed address lines with random traffic
      set_line_swap(1'b1);
      queue_random(500);
      wait_drained();

      // receiver holds off while the sender keeps offering: block backs up
      holds_requested++;
      queue_random(150);
      wait_drained();

      // back to straight lines, no idling on either side
      set_line_swap(1'b0);
      steady = 1'b1;
      queue_random(400);
      wait_drained();
      steady = 1'b0;

      // crossed again, random idling
      set_line_swap(1'b1);
      queue_random(300);
      wait_drained();
      set_line_swap(1'b0);
      queue_random(300);
      wait_drained();

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> pulse_and_saw_sound_generator.f
+incdir+design
design/psg_pkg.sv
design/psg_if.sv
design/psg_pulse.sv
design/pulse_and_saw_sound_generator.sv
sim/tb.sv
